/* rtl/nsfp_pkg.sv */
// ----------------------------------------------------------------------------
// nsfp_pkg: shared types and constants
// Line record passed from the byte front end to the conversion back end,
// and the result snapshot.
// ----------------------------------------------------------------------------
package nsfp_pkg;

  localparam int LINE_BYTES = 100;
  localparam int TIME_CHARS = 6;
  localparam int LEN_W      = $clog2(LINE_BYTES);
  localparam int TIME_LIM   = (TIME_CHARS < 6) ? TIME_CHARS : 6;
  localparam int IVAL_W     = 20;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D1    = 8'h31;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_GSV = 24'h475356;
  localparam logic [23:0] TYPE_VTG = 24'h565447;
  localparam logic [23:0] TYPE_RMC = 24'h524D43;

  localparam logic [47:0] TIME_RESET = 48'h303030303030;

  // scanned number: integer part (saturating), 1e-5 fraction, hundredths
  typedef struct packed {
    logic              neg;
    logic [IVAL_W-1:0] ival;
    logic [16:0]       frac;
    logic [6:0]        hund;
  } num_t;

  typedef struct packed {
    logic        upd_sats;
    logic [7:0]  sats;
    logic        fix_set;
    logic        fix_clr;
    logic        upd_view;
    logic [7:0]  view;
    logic        upd_speed;
    num_t        spd;
    num_t        lat;
    logic        lat_hneg;
    num_t        lon;
    logic        lon_hneg;
    num_t        alt;
    logic        upd_time;
    logic [47:0] tm;
    logic [31:0] bytes;
    logic [31:0] lines;
  } rec_t;

  typedef struct packed {
    logic [31:0] lat;
    logic [31:0] lon;
    logic [24:0] alt;
    logic [24:0] spd;
    logic [7:0]  sats;
    logic [7:0]  view;
    logic        valid;
    logic [47:0] tm;
    logic [31:0] bytes;
    logic [31:0] lines;
  } snap_t;

endpackage

/* rtl/nmea_sentence_field_parser.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_field_parser: NMEA 0183 GGA/GSV/VTG/RMC field parser
// Byte stream in, one position/time/count snapshot out per LF.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  input     push / full    rx_byte
//  result    empty / pop    latitude .. lines_seen (snapshot per LF)
//
//  One byte per cycle is accepted; every byte stalls while full is high.
//  A snapshot goes through the line queue, three-stage degree conversion
//  and commit after its LF is accepted; one LF per cycle while results
//  are taken. Synchronous reset clears the line, the counters and the
//  output state (time text reads "000000"). full rises only when the two-entry
//  line queue fills, which happens while the result queue is not drained.
// ----------------------------------------------------------------------------
module nmea_sentence_field_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               push,
  output logic               full,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic signed [24:0] altitude_cm,
  output logic signed [24:0] speed_centi_kmh,
  output logic [7:0]         sats_used,
  output logic [7:0]         sats_visible,
  output logic               fix_valid,
  output logic [47:0]        utc_time_text,
  output logic [31:0]        bytes_seen,
  output logic [31:0]        lines_seen,
  output logic               empty,
  input  logic               pop
);

  nsfp_pkg::rec_t  f_rec, q_rec;
  nsfp_pkg::snap_t snap;
  logic            rec_push, rec_pop, rec_valid, rec_full;

  nsfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .push     (push),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec      (f_rec)
  );

  nsfp_lineq u_lineq (
    .clk   (clk),
    .rst   (rst),
    .wr    (rec_push),
    .din   (f_rec),
    .rd    (rec_pop),
    .dout  (q_rec),
    .valid (rec_valid),
    .full  (rec_full)
  );

  nsfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (q_rec),
    .rec_pop   (rec_pop),
    .pop       (pop),
    .empty     (empty),
    .snap      (snap)
  );

  assign full            = rec_full;
  assign latitude        = snap.lat;
  assign longitude       = snap.lon;
  assign altitude_cm     = snap.alt;
  assign speed_centi_kmh = snap.spd;
  assign sats_used       = snap.sats;
  assign sats_visible    = snap.view;
  assign fix_valid       = snap.valid;
  assign utc_time_text   = snap.tm;
  assign bytes_seen      = snap.bytes;
  assign lines_seen      = snap.lines;

  a_rec_only_on_lf: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> (push && !full && rx_byte == nsfp_pkg::CH_LF))
    else $error("line record pushed without an accepted LF");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    rec_pop |-> rec_valid)
    else $error("line record popped from an empty queue");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    rec_full |-> !rec_push)
    else $error("line record pushed into a full queue");

endmodule

/* rtl/nsfp_front.sv */
// ----------------------------------------------------------------------------
// nsfp_front: byte front end
// Splits each line into fields as bytes arrive, scans numbers per field and
// emits one line record on every LF.
// ----------------------------------------------------------------------------
module nsfp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      rx_byte,
  input  logic            push,
  input  logic            rec_full,
  output logic            rec_push,
  output nsfp_pkg::rec_t  rec
);

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_BODY  = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t         phase;
    logic           point;
    logic [2:0]     fcnt;
    nsfp_pkg::num_t num;
  } scan_t;

  localparam scan_t SCAN_RST = '{phase: PH_START, point: 1'b0, fcnt: 3'd0, num: '0};
  localparam logic [nsfp_pkg::IVAL_W-1:0] IVAL_MAX = '1;

  function automatic scan_t scan_step(scan_t s, logic [7:0] c);
    scan_t       r;
    logic        dig;
    logic        blank;
    logic        take;
    logic [3:0]  d;
    logic [23:0] wide;
    r     = s;
    take  = 1'b0;
    d     = c[3:0];
    dig   = (c >= nsfp_pkg::CH_D0) && (c <= nsfp_pkg::CH_D9);
    blank = (c == nsfp_pkg::CH_SP) || ((c >= 8'd9) && (c <= 8'd13));
    wide  = {1'b0, s.num.ival, 3'b0} + {3'b0, s.num.ival, 1'b0} + {20'd0, d};
    unique case (s.phase)
      PH_START: begin
        if (blank) begin
          r.phase = PH_START;
        end else if (c == nsfp_pkg::CH_PLUS || c == nsfp_pkg::CH_MINUS) begin
          r.num.neg = (c == nsfp_pkg::CH_MINUS);
          r.phase   = PH_BODY;
        end else begin
          take = 1'b1;
        end
      end
      PH_BODY: take = 1'b1;
      PH_DONE: r.phase = PH_DONE;
      default: r.phase = PH_DONE;
    endcase
    if (take) begin
      r.phase = PH_BODY;
      if (c == nsfp_pkg::CH_DOT && !s.point) begin
        r.point = 1'b1;
      end else if (dig) begin
        if (s.point) begin
          // drop fraction digits past the fifth
          if (s.fcnt < 3'd5) begin
            r.fcnt = s.fcnt + 3'd1;
            unique case (s.fcnt)
              3'd0: begin
                r.num.frac = s.num.frac + 17'(d) * 17'd10000;
                r.num.hund = 7'(d) * 7'd10;
              end
              3'd1: begin
                r.num.frac = s.num.frac + 17'(d) * 17'd1000;
                r.num.hund = s.num.hund + 7'(d);
              end
              3'd2: r.num.frac = s.num.frac + 17'(d) * 17'd100;
              3'd3: r.num.frac = s.num.frac + 17'(d) * 17'd10;
              default: r.num.frac = s.num.frac + 17'(d);
            endcase
          end
        end else begin
          r.num.ival = (wide > 24'(IVAL_MAX)) ? IVAL_MAX : wide[nsfp_pkg::IVAL_W-1:0];
        end
      end else begin
        r.phase = PH_DONE;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] cnt8(nsfp_pkg::num_t n);
    logic [7:0] r;
    if (n.neg) r = 8'd0;
    else if (n.ival > nsfp_pkg::IVAL_W'(255)) r = 8'hFF;
    else r = n.ival[7:0];
    return r;
  endfunction

  logic [nsfp_pkg::LEN_W-1:0] line_length;
  logic                       dead;
  logic [2:0]                 hdr_cnt;
  logic [47:0]                hdr;
  logic [4:0]                 fld;
  scan_t                      scan;
  logic [2:0]                 ccnt;
  nsfp_pkg::num_t             n2, n3, n4, n7, n9;
  logic [7:0]                 fc2, fc3, fc5, fc6;
  logic [47:0]                tm;
  logic                       t1ne;
  logic [31:0]                byte_counter;
  logic [31:0]                line_counter;

  logic  acc, is_lf, store, proc, is_comma;
  scan_t scan_next;
  logic [5:0] tpos;

  assign acc       = push && !rec_full;
  assign is_lf     = (rx_byte == nsfp_pkg::CH_LF);
  assign store     = acc && !is_lf && (rx_byte != nsfp_pkg::CH_CR) &&
                     (line_length < nsfp_pkg::LEN_W'(nsfp_pkg::LINE_BYTES - 1));
  assign proc      = store && !dead && (rx_byte != nsfp_pkg::CH_NUL);
  assign is_comma  = (rx_byte == nsfp_pkg::CH_COMMA);
  assign scan_next = scan_step(scan, rx_byte);
  assign tpos      = 6'(8 * (5 - int'(ccnt)));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
      line_counter <= '0;
      line_length  <= '0;
      dead         <= 1'b0;
      hdr_cnt      <= '0;
      hdr          <= '0;
      fld          <= '0;
      scan         <= SCAN_RST;
      ccnt         <= '0;
      n2 <= '0; n3 <= '0; n4 <= '0; n7 <= '0; n9 <= '0;
      fc2 <= '0; fc3 <= '0; fc5 <= '0; fc6 <= '0;
      tm           <= '0;
      t1ne         <= 1'b0;
    end else begin
      if (acc) byte_counter <= byte_counter + 32'd1;
      if (acc && is_lf) begin
        if (line_length != '0) line_counter <= line_counter + 32'd1;
        line_length <= '0;
        dead        <= 1'b0;
        hdr_cnt     <= '0;
        hdr         <= '0;
        fld         <= '0;
        scan        <= SCAN_RST;
        ccnt        <= '0;
        n2 <= '0; n3 <= '0; n4 <= '0; n7 <= '0; n9 <= '0;
        fc2 <= '0; fc3 <= '0; fc5 <= '0; fc6 <= '0;
        tm          <= '0;
        t1ne        <= 1'b0;
      end else if (store) begin
        line_length <= line_length + 1'b1;
        // a zero byte ends the line for parsing
        if (!dead && rx_byte == nsfp_pkg::CH_NUL) dead <= 1'b1;
        if (proc) begin
          if (hdr_cnt < 3'd6) begin
            hdr     <= {hdr[39:0], rx_byte};
            hdr_cnt <= hdr_cnt + 3'd1;
          end
          if (is_comma) begin
            if (fld != 5'd31) fld <= fld + 5'd1;
            scan <= SCAN_RST;
            ccnt <= '0;
          end else begin
            scan <= scan_next;
            if (ccnt < 3'(nsfp_pkg::TIME_LIM)) ccnt <= ccnt + 3'd1;
            if (ccnt == 3'd0) begin
              if (fld == 5'd2) fc2 <= rx_byte;
              if (fld == 5'd3) fc3 <= rx_byte;
              if (fld == 5'd5) fc5 <= rx_byte;
              if (fld == 5'd6) fc6 <= rx_byte;
            end
            if (fld == 5'd1) begin
              t1ne <= 1'b1;
              if (ccnt < 3'(nsfp_pkg::TIME_LIM)) tm[tpos +: 8] <= rx_byte;
            end
            if (fld == 5'd2) n2 <= scan_next.num;
            if (fld == 5'd3) n3 <= scan_next.num;
            if (fld == 5'd4) n4 <= scan_next.num;
            if (fld == 5'd7) n7 <= scan_next.num;
            if (fld == 5'd9) n9 <= scan_next.num;
          end
        end
      end
    end
  end

  logic talker_ok, is_gga, is_gsv, is_vtg, is_rmc, gga_fix;

  always_comb begin
    talker_ok = (hdr_cnt == 3'd6) && (hdr[47:40] == nsfp_pkg::CH_DOLLAR) &&
                ((hdr[39:32] == nsfp_pkg::CH_G) ||
                 (hdr[39:32] == nsfp_pkg::CH_B && hdr[31:24] == nsfp_pkg::CH_D));
    is_gga  = talker_ok && (hdr[23:0] == nsfp_pkg::TYPE_GGA);
    is_gsv  = talker_ok && (hdr[23:0] == nsfp_pkg::TYPE_GSV);
    is_vtg  = talker_ok && (hdr[23:0] == nsfp_pkg::TYPE_VTG);
    is_rmc  = talker_ok && (hdr[23:0] == nsfp_pkg::TYPE_RMC);
    gga_fix = (fld >= 5'd9) && (fc6 != nsfp_pkg::CH_D0) && (fc6 != nsfp_pkg::CH_NUL);

    rec.upd_sats  = is_gga && (fld >= 5'd7);
    rec.sats      = cnt8(n7);
    rec.fix_set   = is_gga && gga_fix;
    rec.fix_clr   = is_gga && !gga_fix;
    rec.upd_view  = is_gsv && (fld >= 5'd3) && (fc3 >= nsfp_pkg::CH_D0) &&
                    (fc3 <= nsfp_pkg::CH_D9) && (fc2 == nsfp_pkg::CH_D1);
    rec.view      = cnt8(n3);
    rec.upd_speed = is_vtg && (fld >= 5'd7);
    rec.spd       = n7;
    rec.lat       = n2;
    rec.lat_hneg  = (fc3 == nsfp_pkg::CH_S) || (fc3 == nsfp_pkg::CH_W);
    rec.lon       = n4;
    rec.lon_hneg  = (fc5 == nsfp_pkg::CH_S) || (fc5 == nsfp_pkg::CH_W);
    rec.alt       = n9;
    rec.upd_time  = is_rmc && (fld >= 5'd1) && t1ne;
    rec.tm        = tm;
    rec.bytes     = byte_counter + 32'd1;
    rec.lines     = line_counter + ((line_length != '0) ? 32'd1 : 32'd0);
  end

  assign rec_push = acc && is_lf;

endmodule

/* rtl/nsfp_lineq.sv */
// ----------------------------------------------------------------------------
// nsfp_lineq: two-entry line record queue
// Decouples the byte front end from the conversion pipeline.
// ----------------------------------------------------------------------------
module nsfp_lineq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  nsfp_pkg::rec_t din,
  input  logic           rd,
  output nsfp_pkg::rec_t dout,
  output logic           valid,
  output logic           full
);

  nsfp_pkg::rec_t mem [2];
  logic           wp, rp;
  logic [1:0]     cnt;

  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* rtl/nsfp_back.sv */
// ----------------------------------------------------------------------------
// nsfp_back: conversion back end
// Converts DDDMM.mmmmm to 1e-7 degrees in a three-stage pipeline, commits
// the output state in line order and queues one snapshot per line.
// ----------------------------------------------------------------------------
module nsfp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  input  nsfp_pkg::rec_t  rec,
  output logic            rec_pop,
  input  logic            pop,
  output logic            empty,
  output nsfp_pkg::snap_t snap
);

  typedef struct packed {
    logic        big;
    logic [7:0]  q;
    logic [25:0] x;
  } lane_t;

  localparam logic [30:0] DEG_MAX = 31'd1800000000;

  function automatic lane_t lane_s1(nsfp_pkg::num_t n);
    lane_t       r;
    logic [27:0] p;
    p     = 28'(n.ival[14:0]) * 28'd5243;
    r.big = (n.ival >= nsfp_pkg::IVAL_W'(18000));
    r.q   = p[26:19];
    r.x   = '0;
    return r;
  endfunction

  function automatic lane_t lane_s2(lane_t l, nsfp_pkg::num_t n);
    lane_t       r;
    logic [14:0] rem;
    rem = n.ival[14:0] - 15'(l.q) * 15'd100;
    r   = l;
    r.x = 26'(rem[6:0]) * 26'd500000 + 26'(n.frac) * 26'd5;
    return r;
  endfunction

  function automatic lane_t lane_s3(lane_t l);
    lane_t       r;
    logic [57:0] p;
    p   = {32'd0, l.x} * {26'd0, 32'hAAAAAAAB};
    r   = l;
    r.x = {1'b0, p[57:33]};
    return r;
  endfunction

  function automatic logic [31:0] deg_out(lane_t l, logic neg);
    logic [30:0] v;
    logic [30:0] m;
    v = 31'(l.q) * 31'd10000000 + 31'(l.x);
    m = (l.big || v > DEG_MAX) ? DEG_MAX : v;
    return neg ? -{1'b0, m} : {1'b0, m};
  endfunction

  function automatic logic [24:0] centi(nsfp_pkg::num_t n, logic [24:0] neg_lim);
    logic        big;
    logic [24:0] mag;
    logic [24:0] r;
    big = (n.ival >= nsfp_pkg::IVAL_W'(100000));
    mag = 25'(n.ival[16:0]) * 25'd100 + 25'(n.hund);
    if (n.neg) r = (big || mag > neg_lim) ? -neg_lim : -mag;
    else r = big ? 25'd10000000 : mag;
    return r;
  endfunction

  logic           s1_v, s2_v, s3_v;
  nsfp_pkg::rec_t s1, s2, s3;
  lane_t          s1_la, s1_lo, s2_la, s2_lo, s3_la, s3_lo;

  logic [31:0] lat_r, lon_r;
  logic [24:0] alt_r, spd_r;
  logic [7:0]  sats_r, view_r;
  logic        valid_r;
  logic [47:0] tm_r;

  nsfp_pkg::snap_t nxt;
  nsfp_pkg::snap_t oq [2];
  logic            owp, orp;
  logic [1:0]      ocnt;
  logic            ofull, adv, commit, opop;

  assign ofull   = (ocnt == 2'd2);
  assign empty   = (ocnt == 2'd0);
  assign snap    = oq[orp];
  assign opop    = pop && !empty;
  // the whole pipeline holds while the snapshot queue is full and stage three holds a record
  assign adv     = !s3_v || !ofull;
  assign commit  = s3_v && adv;
  assign rec_pop = adv && rec_valid;

  always_comb begin
    nxt.lat   = lat_r;
    nxt.lon   = lon_r;
    nxt.alt   = alt_r;
    nxt.spd   = spd_r;
    nxt.sats  = sats_r;
    nxt.view  = view_r;
    nxt.valid = valid_r;
    nxt.tm    = tm_r;
    nxt.bytes = s3.bytes;
    nxt.lines = s3.lines;
    if (s3.upd_sats) nxt.sats = s3.sats;
    if (s3.fix_set) begin
      nxt.lat   = deg_out(s3_la, s3.lat.neg ^ s3.lat_hneg);
      nxt.lon   = deg_out(s3_lo, s3.lon.neg ^ s3.lon_hneg);
      nxt.alt   = centi(s3.alt, 25'd100000);
      nxt.valid = 1'b1;
    end
    if (s3.fix_clr) nxt.valid = 1'b0;
    if (s3.upd_view) nxt.view = s3.view;
    if (s3.upd_speed) nxt.spd = centi(s3.spd, 25'd10000000);
    if (s3.upd_time) nxt.tm = s3.tm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= rec;
      s1_la <= lane_s1(rec.lat);
      s1_lo <= lane_s1(rec.lon);
      s2    <= s1;
      s2_la <= lane_s2(s1_la, s1.lat);
      s2_lo <= lane_s2(s1_lo, s1.lon);
      s3    <= s2;
      s3_la <= lane_s3(s2_la);
      s3_lo <= lane_s3(s2_lo);
    end
    if (commit) oq[owp] <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      owp     <= 1'b0;
      orp     <= 1'b0;
      ocnt    <= 2'd0;
      lat_r   <= '0;
      lon_r   <= '0;
      alt_r   <= '0;
      spd_r   <= '0;
      sats_r  <= '0;
      view_r  <= '0;
      valid_r <= 1'b0;
      tm_r    <= nsfp_pkg::TIME_RESET;
    end else begin
      if (adv) begin
        s1_v <= rec_valid;
        s2_v <= s1_v;
        s3_v <= s2_v;
      end
      if (commit) begin
        lat_r   <= nxt.lat;
        lon_r   <= nxt.lon;
        alt_r   <= nxt.alt;
        spd_r   <= nxt.spd;
        sats_r  <= nxt.sats;
        view_r  <= nxt.view;
        valid_r <= nxt.valid;
        tm_r    <= nxt.tm;
        owp     <= ~owp;
      end
      if (opop) orp <= ~orp;
      ocnt <= ocnt + {1'b0, commit} - {1'b0, opop};
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: NMEA sentence field parser testbench
// Sends GGA/GSV/VTG/RMC sentences, edge-case lines and noise byte by byte.
// Predicts each LF snapshot in the testbench and checks it field by field,
// with random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  import nsfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic               clk = 0;
  logic               rst = 1;
  logic [7:0]         rx_byte = '0;
  logic               push = 0;
  logic               full;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [24:0] altitude_cm;
  logic signed [24:0] speed_centi_kmh;
  logic [7:0]         sats_used;
  logic [7:0]         sats_visible;
  logic               fix_valid;
  logic [47:0]        utc_time_text;
  logic [31:0]        bytes_seen;
  logic [31:0]        lines_seen;
  logic               empty;
  logic               pop = 0;

  nmea_sentence_field_parser dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // prediction state
  logic [7:0]  line_mem [LINE_BYTES];
  int          line_len, eff;
  longint      lat_q, lon_q, alt_q, spd_q;
  int          sats_q, view_q;
  bit          valid_q;
  logic [47:0] time_q;
  logic [31:0] nbytes, nlines;

  snap_t snap_q[$];
  int    errors = 0;
  int    cycles = 0;
  int    sent = 0;
  bit    no_idle = 0;
  bit    hold_go = 0, hold_ack = 0;
  int    hold_left = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit span(int k, output int s, output int e);
    int f, st;
    f = 0; st = 0; s = 0; e = 0;
    for (int i = 0; i <= eff; i++)
      if (i == eff || line_mem[i] == CH_COMMA) begin
        if (f == k) begin
          s = st; e = i;
          return 1;
        end
        f++;
        st = i + 1;
      end
    return 0;
  endfunction

  function automatic int field_total();
    int n;
    n = 1;
    for (int i = 0; i < eff; i++) if (line_mem[i] == CH_COMMA) n++;
    return n;
  endfunction

  function automatic logic [7:0] lead_char(int k);
    int s, e;
    if (!span(k, s, e) || s >= e) return 8'h00;
    return line_mem[s];
  endfunction

  // field value in units of 1e-5
  function automatic longint scan_num(int k, bit int_only);
    int s, e, i, frac;
    longint mag, w;
    bit neg, pt;
    logic [7:0] c;
    mag = 0; neg = 0; pt = 0; frac = 0;
    if (!span(k, s, e)) return 0;
    i = s;
    while (i < e && (line_mem[i] == CH_SP || (line_mem[i] >= 9 && line_mem[i] <= 13))) i++;
    if (i < e && (line_mem[i] == CH_PLUS || line_mem[i] == CH_MINUS)) begin
      neg = line_mem[i] == CH_MINUS;
      i++;
    end
    for (; i < e; i++) begin
      c = line_mem[i];
      if (c == CH_DOT && !pt) begin
        pt = 1;
        continue;
      end
      if (c < CH_D0 || c > CH_D9) break;
      if (pt) begin
        if (int_only) break;
        if (frac < 5) begin
          w = 1;
          for (int j = frac; j < 4; j++) w = w * 10;
          mag += longint'(c - CH_D0) * w;
          frac++;
        end
      end else begin
        mag = mag * 10 + longint'(c - CH_D0) * 100000;
        if (mag > 64'sd1000000000000000) mag = 64'sd1000000000000000;
      end
    end
    return neg ? -mag : mag;
  endfunction

  function automatic longint to_degrees(int k, int hk);
    longint r, d, v;
    logic [7:0] h;
    r = scan_num(k, 0);
    d = r / 10000000;
    v = d * 10000000 + ((r - d * 10000000) * 5) / 3;
    h = lead_char(hk);
    if (h == CH_S || h == CH_W) v = -v;
    return clip(v, -1800000000, 1800000000);
  endfunction

  function automatic void parse_sentence();
    int n, s, e;
    logic [7:0] f, c;
    logic [23:0] kind;
    logic [47:0] t;
    eff = 0;
    while (eff < line_len && line_mem[eff] != CH_NUL) eff++;
    if (eff < 6 || line_mem[0] != CH_DOLLAR) return;
    if (!(line_mem[1] == CH_G || (line_mem[1] == CH_B && line_mem[2] == CH_D))) return;
    n = field_total();
    kind = {line_mem[3], line_mem[4], line_mem[5]};
    if (kind == TYPE_GGA) begin
      if (n >= 8) sats_q = int'(clip(scan_num(7, 1) / 100000, 0, 255));
      f = lead_char(6);
      if (n >= 10 && f != CH_D0 && f != CH_NUL) begin
        lat_q = to_degrees(2, 3);
        lon_q = to_degrees(4, 5);
        alt_q = clip(scan_num(9, 0) / 1000, -100000, 10000000);
        valid_q = 1;
      end else begin
        valid_q = 0;
      end
    end else if (kind == TYPE_GSV) begin
      c = lead_char(3);
      if (n >= 4 && c >= CH_D0 && c <= CH_D9 && lead_char(2) == CH_D1)
        view_q = int'(clip(scan_num(3, 1) / 100000, 0, 255));
    end else if (kind == TYPE_VTG) begin
      if (n >= 8) spd_q = clip(scan_num(7, 0) / 1000, -10000000, 10000000);
    end else if (kind == TYPE_RMC) begin
      if (n >= 2 && span(1, s, e) && s < e) begin
        t = '0;
        for (int i = 0; i < 6; i++)
          t = {t[39:0], (i < TIME_CHARS && s + i < e) ? line_mem[s + i] : 8'h00};
        time_q = t;
      end
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    snap_t x;
    nbytes++;
    if (b == CH_LF) begin
      if (line_len > 0) nlines++;
      parse_sentence();
      line_len = 0;
      x.lat = lat_q[31:0];
      x.lon = lon_q[31:0];
      x.alt = alt_q[24:0];
      x.spd = spd_q[24:0];
      x.sats = sats_q[7:0];
      x.view = view_q[7:0];
      x.valid = valid_q;
      x.tm = time_q;
      x.bytes = nbytes;
      x.lines = nlines;
      snap_q.push_back(x);
    end else if (b != CH_CR && line_len < LINE_BYTES - 1) begin
      line_mem[line_len] = b;
      line_len++;
    end
  endfunction

  // sender: random gaps, then offer the byte until accepted
  task automatic send_byte(logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 36) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    predict_byte(b);
    sent++;
  endtask

  task automatic send_line(string str);
    for (int i = 0; i < str.len(); i++) send_byte(str[i]);
    send_byte(CH_LF);
  endtask

  // receiver and checker
  task automatic chk(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    snap_t want;
    if (!rst && pop && !empty) begin
      if (snap_q.size() == 0) begin
        $display("%0t unexpected result: lines_seen %0d", $time, lines_seen);
        errors++;
      end else begin
        want = snap_q.pop_front();
        chk("latitude", want.lat, $unsigned(latitude));
        chk("longitude", want.lon, $unsigned(longitude));
        chk("altitude_cm", want.alt, $unsigned(altitude_cm));
        chk("speed_centi_kmh", want.spd, $unsigned(speed_centi_kmh));
        chk("sats_used", want.sats, sats_used);
        chk("sats_visible", want.view, sats_visible);
        chk("fix_valid", want.valid, fix_valid);
        chk("utc_time_text", want.tm, utc_time_text);
        chk("bytes_seen", want.bytes, bytes_seen);
        chk("lines_seen", want.lines, lines_seen);
      end
    end
    if (hold_go != hold_ack) begin
      hold_ack <= hold_go;
      hold_left <= HOLD_CYCLES;
      pop <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 0;
    end else begin
      pop <= no_idle || $urandom_range(99) >= 36;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // random stimulus helpers
  function automatic string rand_num();
    string r;
    r = "";
    if ($urandom_range(9) == 0) r = " ";
    case ($urandom_range(5))
      0: r = {r, "-"};
      1: r = {r, "+"};
      default: ;
    endcase
    repeat ($urandom_range(0, $urandom_range(3) == 0 ? 13 : 5))
      r = $sformatf("%s%0d", r, $urandom_range(9));
    if ($urandom_range(2) != 0) begin
      r = {r, "."};
      repeat ($urandom_range(0, 8)) r = $sformatf("%s%0d", r, $urandom_range(9));
    end
    if ($urandom_range(15) == 0) r = {r, "x"};
    return r;
  endfunction

  function automatic string rand_sentence();
    string talk[] = '{"$GP", "$GN", "$BD", "$GL", "$XX", "$BX"};
    string kinds[] = '{"GGA", "GSV", "VTG", "RMC", "GGA", "RMC", "ABC"};
    string fixes[] = '{"", "0", "1", "2", "6"};
    string hemi[] = '{"N", "S", "E", "W", ""};
    string kind, r;
    int n;
    kind = kinds[$urandom_range(kinds.size() - 1)];
    r = {talk[$urandom_range(talk.size() - 1)], kind};
    n = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(10, 15);
    for (int k = 1; k <= n; k++) begin
      r = {r, ","};
      if (kind == "GGA" && k == 6) r = {r, fixes[$urandom_range(4)]};
      else if (kind == "GGA" && (k == 3 || k == 5)) r = {r, hemi[$urandom_range(4)]};
      else if (kind == "GSV" && k == 2 && $urandom_range(1)) r = {r, "1"};
      else if (kind == "RMC" && k == 1 && $urandom_range(1))
        r = $sformatf("%s%06d.%02d", r, $urandom_range(235959), $urandom_range(99));
      else r = {r, rand_num()};
    end
    return r;
  endfunction

  // tests
  task automatic test_gga();
    send_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_line("$GNGGA,0,8959.9999999,S,17959.99999,W,2,300,1,-2000.5,M");
    send_line("$BDGGA,0,99999999999999,N,-99999,E,1,-3,1,99999999.99,M");
    send_line("$GPGGA,0,1000.5,N,2000.5,E,0,05,1,10,M");
    send_line("$GPGGA,0,1000.5,N,2000.5,E,,07,1,10,M");
    send_line("$GPGGA,0,1,N,2,E,1,09,1");
    send_line("$GPGGA,1,2");
  endtask

  task automatic test_other_types();
    send_line("$GPGSV,3,1,11,07,79,048,42");
    send_line("$GPGSV,3,2,09,07,79,048,42");
    send_line("$GLGSV,3,1,x9");
    send_line("$GPGSV,3,1,999");
    send_line("$GPVTG,054.7,T,034.4,M,005.5,N, 010.2,K");
    send_line("$GPVTG,0,T,0,M,0,N,-999999.999,K");
    send_line("$GPVTG,0,T,0,M,0,N,+123456789");
    send_line("$GPRMC,123519.00,A,4807.038,N");
    send_line("$GPRMC,12");
    send_line("$GPRMC,,A");
  endtask

  task automatic test_line_edges();
    string head;
    head = "$GPRMC,1";
    send_line("\r$GPVTG,1,,,,,,,77.7\r");
    send_line("$GPGG");
    send_line("$XXGGA,0,1,N,1,E,1,4,1,1");
    send_line("");
    for (int i = 0; i < 110; i++) send_byte(i < 100 ? "1" : ",");
    send_byte(CH_LF);
    for (int i = 0; i < 8; i++) send_byte(head[i]);
    send_byte(CH_NUL);
    send_line("9,99");
  endtask

  task automatic test_random();
    int start;
    start = sent;
    while (sent - start < 600) begin
      if (sent - start > 200 && sent - start < 350) no_idle = 1;
      else no_idle = 0;
      if ($urandom_range(9) < 8) send_line(rand_sentence());
      else begin
        repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(255)));
        if ($urandom_range(1)) send_byte(CH_LF);
      end
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    hold_go = !hold_go;
    no_idle = 1;
    repeat (6) send_line("$GPVTG,1,,,,,,,2.5");
    repeat (10) send_byte(CH_LF);
    no_idle = 0;
  endtask

  initial begin
    line_len = 0; eff = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    lat_q = 0; lon_q = 0; alt_q = 0; spd_q = 0;
    sats_q = 0; view_q = 0; valid_q = 0;
    time_q = TIME_RESET; nbytes = '0; nlines = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_gga();
    test_other_types();
    test_line_edges();
    test_backpressure();
    test_random();
    push <= 0;
    while (snap_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
